// ----- hdl/cssg_pkg.sv -----
// cssg_pkg: shared types, constants and helper functions for the stencil grid smoother
// depends on nothing; used by cssg_if, cssg_csr, cssg_engine and the top level
`default_nettype none
package cssg_pkg;

   localparam int GRID_EDGE = 32;
   localparam int MAX_DEGREE = 6;
   localparam int CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;
   localparam int CELL_BITS = $clog2(CELLS);
   localparam int COORD_BITS = $clog2(GRID_EDGE);
   localparam int NUM_COEF = MAX_DEGREE + 1;
   localparam int NUM_REGS = NUM_COEF + 1;
   localparam int REG_BITS = $clog2(NUM_REGS);

   localparam int CHARGE_W = 32;
   localparam int COEF_W = 32;
   localparam int RECUR_W = 48;
   localparam int ACC_W = RECUR_W + 6;
   localparam int PROD_W = CHARGE_W + COEF_W;

   // sequencer steps within one cell
   localparam int NUM_TAPS = 19;
   localparam int LAST_TAP = NUM_TAPS - 1;
   localparam int ACC_LAST = NUM_TAPS;
   localparam int Z_STEP = NUM_TAPS + 1;
   localparam int WB_STEP = NUM_TAPS + 2;
   localparam int STEP_BITS = $clog2(WB_STEP + 1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [CELL_BITS-1:0] addr_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_START = 2'd1,
      CMD_READ  = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_READ = 1'b0,
      KIND_DONE = 1'b1
   } kind_type;

   typedef enum logic [REG_BITS-1:0] {
      REG_DEGREE = REG_BITS'(0),
      REG_COEF0  = REG_BITS'(1)
   } reg_index_type;

   typedef enum logic [1:0] {
      OFF_ZERO  = 2'd0,
      OFF_MINUS = 2'd1,
      OFF_PLUS  = 2'd2,
      OFF_NONE  = 2'd3
   } offset_type;

   typedef enum logic [1:0] {
      WT_CENTRE = 2'd0,
      WT_FACE   = 2'd1,
      WT_EDGE   = 2'd2,
      WT_NONE   = 2'd3
   } weight_type;

   typedef struct packed {
      offset_type di;
      offset_type dj;
      offset_type dk;
      weight_type wt;
   } tap_type;

   typedef struct packed {
      logic [2:0] degree;
      logic [NUM_COEF-1:0][COEF_W-1:0] coef;
   } cfg_type;

   // engine access to the charge memory
   typedef struct packed {
      logic busy;
      logic done;
      logic re;
      addr_type raddr;
      logic we;
      addr_type waddr;
      logic [CHARGE_W-1:0] wdata;
   } eng_mem_type;

   function automatic tap_type tap_at(input logic [STEP_BITS-1:0] s);
      tap_type t;
      t = '{OFF_ZERO, OFF_ZERO, OFF_ZERO, WT_CENTRE};
      unique case (s)
         STEP_BITS'(1):  t = '{OFF_MINUS, OFF_ZERO, OFF_ZERO, WT_FACE};
         STEP_BITS'(2):  t = '{OFF_PLUS, OFF_ZERO, OFF_ZERO, WT_FACE};
         STEP_BITS'(3):  t = '{OFF_ZERO, OFF_MINUS, OFF_ZERO, WT_FACE};
         STEP_BITS'(4):  t = '{OFF_ZERO, OFF_PLUS, OFF_ZERO, WT_FACE};
         STEP_BITS'(5):  t = '{OFF_ZERO, OFF_ZERO, OFF_MINUS, WT_FACE};
         STEP_BITS'(6):  t = '{OFF_ZERO, OFF_ZERO, OFF_PLUS, WT_FACE};
         STEP_BITS'(7):  t = '{OFF_MINUS, OFF_MINUS, OFF_ZERO, WT_EDGE};
         STEP_BITS'(8):  t = '{OFF_MINUS, OFF_PLUS, OFF_ZERO, WT_EDGE};
         STEP_BITS'(9):  t = '{OFF_PLUS, OFF_MINUS, OFF_ZERO, WT_EDGE};
         STEP_BITS'(10): t = '{OFF_PLUS, OFF_PLUS, OFF_ZERO, WT_EDGE};
         STEP_BITS'(11): t = '{OFF_MINUS, OFF_ZERO, OFF_MINUS, WT_EDGE};
         STEP_BITS'(12): t = '{OFF_MINUS, OFF_ZERO, OFF_PLUS, WT_EDGE};
         STEP_BITS'(13): t = '{OFF_PLUS, OFF_ZERO, OFF_MINUS, WT_EDGE};
         STEP_BITS'(14): t = '{OFF_PLUS, OFF_ZERO, OFF_PLUS, WT_EDGE};
         STEP_BITS'(15): t = '{OFF_ZERO, OFF_MINUS, OFF_MINUS, WT_EDGE};
         STEP_BITS'(16): t = '{OFF_ZERO, OFF_MINUS, OFF_PLUS, WT_EDGE};
         STEP_BITS'(17): t = '{OFF_ZERO, OFF_PLUS, OFF_MINUS, WT_EDGE};
         STEP_BITS'(18): t = '{OFF_ZERO, OFF_PLUS, OFF_PLUS, WT_EDGE};
         default:        t = '{OFF_ZERO, OFF_ZERO, OFF_ZERO, WT_CENTRE};
      endcase
      return t;
   endfunction

   // periodic neighbor coordinate
   function automatic coord_type wrap(input coord_type c, input offset_type o);
      coord_type r;
      r = c;
      unique case (o)
         OFF_MINUS: r = (c == '0) ? coord_type'(GRID_EDGE - 1) : coord_type'(c - 1'b1);
         OFF_PLUS:  r = (c == coord_type'(GRID_EDGE - 1)) ? '0 : coord_type'(c + 1'b1);
         default:   r = c;
      endcase
      return r;
   endfunction

   function automatic addr_type addr_of(input coord_type i, input coord_type j,
                                        input coord_type k);
      return addr_type'(CELL_BITS'(i) * CELL_BITS'(GRID_EDGE * GRID_EDGE)
                        + CELL_BITS'(j) * CELL_BITS'(GRID_EDGE) + CELL_BITS'(k));
   endfunction

endpackage
`default_nettype wire

// ----- hdl/cssg_if.sv -----
// cssg_if: handshake channel interfaces for requests, responses and register writes
// depends on cssg_pkg
`default_nettype none
interface cssg_req_if;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [14:0] cell_index;
   logic signed [31:0] charge;
   modport source(output valid, cmd, cell_index, charge, input ready);
   modport sink(input valid, cmd, cell_index, charge, output ready);
endinterface

interface cssg_rsp_if;
   logic valid;
   logic ready;
   logic kind;
   logic signed [31:0] value;
   modport source(output valid, kind, value, input ready);
   modport sink(input valid, kind, value, output ready);
endinterface

interface cssg_csr_if;
   logic valid;
   logic ready;
   logic [cssg_pkg::REG_BITS-1:0] index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/cssg_ram.sv -----
// cssg_ram: generic single write port, single read port memory with registered read
// depends on nothing
`default_nettype none
module cssg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic clock,
   input  wire logic we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

// ----- hdl/cssg_csr.sv -----
// cssg_csr: configuration registers (degree and Chebyshev coefficients)
// depends on cssg_pkg and cssg_if
`default_nettype none
module cssg_csr (
   input  wire logic clock,
   input  wire logic reset,
   cssg_csr_if.sink csr_chan,
   output cssg_pkg::cfg_type cfg
);
   logic [2:0] degree_ff;
   logic [cssg_pkg::NUM_COEF-1:0][cssg_pkg::COEF_W-1:0] coef_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg.degree = degree_ff;
   assign cfg.coef = coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 3'd1;
         coef_ff <= '0;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == cssg_pkg::REG_DEGREE) begin
            degree_ff <= csr_chan.data[2:0];
         end else if (csr_chan.index >= cssg_pkg::REG_COEF0) begin
            coef_ff[csr_chan.index - cssg_pkg::REG_COEF0] <= csr_chan.data;
         end
      end
   end
endmodule
`default_nettype wire

// ----- hdl/cssg_engine.sv -----
// cssg_engine: Clenshaw recurrence sequencer over the grid, one stencil tap per cycle
// depends on cssg_pkg and cssg_ram; holds the two recurrence memories
`default_nettype none
module cssg_engine (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  cssg_pkg::cfg_type cfg,
   input  wire logic [cssg_pkg::CHARGE_W-1:0] q_rdata,
   output cssg_pkg::eng_mem_type eng
);
   logic busy_ff, done_ff, sel_ff;
   logic [cssg_pkg::STEP_BITS-1:0] step_ff;
   logic [2:0] pass_ff;
   cssg_pkg::coord_type i_ff, j_ff, k_ff;
   logic signed [cssg_pkg::ACC_W-1:0] acc_ff;
   logic signed [cssg_pkg::PROD_W-1:0] prod_ff;
   logic signed [cssg_pkg::RECUR_W-1:0] z_ff;

   logic [2:0] top, dsel;
   logic final_pass, last_cell;
   cssg_pkg::tap_type tap, tap_prev;
   cssg_pkg::addr_type nb_addr, cur_addr;
   logic rd_b1, rd_b2, wb, we_recur;
   logic [cssg_pkg::RECUR_W-1:0] r0_q, r1_q;
   logic signed [cssg_pkg::RECUR_W-1:0] b1_val, b2_val;
   logic signed [cssg_pkg::ACC_W-1:0] b1_ext, weighted;
   logic signed [cssg_pkg::ACC_W-5:0] z_sh;
   logic signed [cssg_pkg::RECUR_W-1:0] z_in;
   logic signed [cssg_pkg::PROD_W-21:0] sc;
   logic signed [cssg_pkg::RECUR_W+2:0] t_sum;
   logic signed [cssg_pkg::RECUR_W-1:0] t_sat;
   logic signed [cssg_pkg::RECUR_W-9:0] t_sh;
   logic [cssg_pkg::CHARGE_W-1:0] q_out;

   assign top = (cfg.degree > 3'(cssg_pkg::MAX_DEGREE)) ? 3'(cssg_pkg::MAX_DEGREE)
                                                        : cfg.degree;
   assign dsel = top - pass_ff;
   assign final_pass = (pass_ff == top);
   assign last_cell = (i_ff == cssg_pkg::coord_type'(cssg_pkg::GRID_EDGE - 1))
                   && (j_ff == cssg_pkg::coord_type'(cssg_pkg::GRID_EDGE - 1))
                   && (k_ff == cssg_pkg::coord_type'(cssg_pkg::GRID_EDGE - 1));

   assign tap = cssg_pkg::tap_at(step_ff);
   assign tap_prev = cssg_pkg::tap_at(step_ff - 1'b1);
   assign nb_addr = cssg_pkg::addr_of(cssg_pkg::wrap(i_ff, tap.di),
                                      cssg_pkg::wrap(j_ff, tap.dj),
                                      cssg_pkg::wrap(k_ff, tap.dk));
   assign cur_addr = cssg_pkg::addr_of(i_ff, j_ff, k_ff);
   assign rd_b1 = busy_ff && (step_ff <= cssg_pkg::STEP_BITS'(cssg_pkg::LAST_TAP));
   assign rd_b2 = busy_ff && (step_ff == '0);
   assign wb = busy_ff && (step_ff == cssg_pkg::STEP_BITS'(cssg_pkg::WB_STEP));
   assign we_recur = wb && !final_pass;

   // b1 lives in memory sel, b2 in the other one, which also takes the new value
   cssg_ram #(.WIDTH(cssg_pkg::RECUR_W), .DEPTH(cssg_pkg::CELLS)) u_recur0 (
      .clock(clock), .we(we_recur && sel_ff), .waddr(cur_addr), .wdata(t_sat),
      .re(sel_ff ? rd_b2 : rd_b1), .raddr(sel_ff ? cur_addr : nb_addr), .rdata_ff(r0_q)
   );
   cssg_ram #(.WIDTH(cssg_pkg::RECUR_W), .DEPTH(cssg_pkg::CELLS)) u_recur1 (
      .clock(clock), .we(we_recur && !sel_ff), .waddr(cur_addr), .wdata(t_sat),
      .re(sel_ff ? rd_b1 : rd_b2), .raddr(sel_ff ? nb_addr : cur_addr), .rdata_ff(r1_q)
   );

   // first pass sees b1 = b2 = 0, second pass sees b2 = 0
   assign b1_val = (pass_ff == 3'd0) ? '0 : (sel_ff ? r1_q : r0_q);
   assign b2_val = (pass_ff <= 3'd1) ? '0 : (sel_ff ? r0_q : r1_q);
   assign b1_ext = cssg_pkg::ACC_W'(b1_val);

   always_comb begin
      unique case (tap_prev.wt)
         cssg_pkg::WT_CENTRE: weighted = -(b1_ext <<< 3);
         cssg_pkg::WT_FACE:   weighted = b1_ext <<< 1;
         default:             weighted = b1_ext;
      endcase
   end

   assign z_sh = acc_ff[cssg_pkg::ACC_W-1:4];
   always_comb begin
      if (z_sh[cssg_pkg::ACC_W-5:cssg_pkg::RECUR_W-1] != '0
          && z_sh[cssg_pkg::ACC_W-5:cssg_pkg::RECUR_W-1] != '1) begin
         z_in = z_sh[cssg_pkg::ACC_W-5] ? {1'b1, {(cssg_pkg::RECUR_W-1){1'b0}}}
                                       : {1'b0, {(cssg_pkg::RECUR_W-1){1'b1}}};
      end else begin
         z_in = z_sh[cssg_pkg::RECUR_W-1:0];
      end
   end

   assign sc = prod_ff[cssg_pkg::PROD_W-1:20];
   always_comb begin
      t_sum = (final_pass ? (cssg_pkg::RECUR_W+3)'(z_ff)
                          : ((cssg_pkg::RECUR_W+3)'(z_ff) <<< 1))
            - (cssg_pkg::RECUR_W+3)'(b2_val) + (cssg_pkg::RECUR_W+3)'(sc);
      if (t_sum[cssg_pkg::RECUR_W+2:cssg_pkg::RECUR_W-1] != '0
          && t_sum[cssg_pkg::RECUR_W+2:cssg_pkg::RECUR_W-1] != '1) begin
         t_sat = t_sum[cssg_pkg::RECUR_W+2] ? {1'b1, {(cssg_pkg::RECUR_W-1){1'b0}}}
                                           : {1'b0, {(cssg_pkg::RECUR_W-1){1'b1}}};
      end else begin
         t_sat = t_sum[cssg_pkg::RECUR_W-1:0];
      end
      t_sh = t_sat[cssg_pkg::RECUR_W-1:8];
      if (t_sh[cssg_pkg::RECUR_W-9:cssg_pkg::CHARGE_W-1] != '0
          && t_sh[cssg_pkg::RECUR_W-9:cssg_pkg::CHARGE_W-1] != '1) begin
         q_out = t_sh[cssg_pkg::RECUR_W-9] ? {1'b1, {(cssg_pkg::CHARGE_W-1){1'b0}}}
                                          : {1'b0, {(cssg_pkg::CHARGE_W-1){1'b1}}};
      end else begin
         q_out = t_sh[cssg_pkg::CHARGE_W-1:0];
      end
   end

   assign eng.busy = busy_ff;
   assign eng.done = done_ff;
   assign eng.re = rd_b2;
   assign eng.raddr = cur_addr;
   assign eng.we = wb && final_pass;
   assign eng.waddr = cur_addr;
   assign eng.wdata = q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         sel_ff <= 1'b0;
         step_ff <= '0;
         pass_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else begin
         done_ff <= wb && last_cell && final_pass;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            pass_ff <= '0;
            i_ff <= '0;
            j_ff <= '0;
            k_ff <= '0;
         end else if (busy_ff) begin
            if (wb) begin
               step_ff <= '0;
               if (k_ff == cssg_pkg::coord_type'(cssg_pkg::GRID_EDGE - 1)) begin
                  k_ff <= '0;
                  if (j_ff == cssg_pkg::coord_type'(cssg_pkg::GRID_EDGE - 1)) begin
                     j_ff <= '0;
                     i_ff <= (i_ff == cssg_pkg::coord_type'(cssg_pkg::GRID_EDGE - 1))
                             ? '0 : cssg_pkg::coord_type'(i_ff + 1'b1);
                  end else begin
                     j_ff <= cssg_pkg::coord_type'(j_ff + 1'b1);
                  end
               end else begin
                  k_ff <= cssg_pkg::coord_type'(k_ff + 1'b1);
               end
               if (last_cell) begin
                  if (final_pass) begin
                     busy_ff <= 1'b0;
                  end else begin
                     pass_ff <= pass_ff + 3'd1;
                     sel_ff <= !sel_ff;
                  end
               end
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         if (step_ff == '0) begin
            acc_ff <= '0;
         end else if (step_ff <= cssg_pkg::STEP_BITS'(cssg_pkg::ACC_LAST)) begin
            acc_ff <= acc_ff + weighted;
         end
         if (step_ff == cssg_pkg::STEP_BITS'(1)) begin
            prod_ff <= cssg_pkg::PROD_W'($signed(cfg.coef[dsel]))
                     * cssg_pkg::PROD_W'($signed(q_rdata));
         end
         if (step_ff == cssg_pkg::STEP_BITS'(cssg_pkg::Z_STEP)) begin
            z_ff <= z_in;
         end
      end
   end
endmodule
`default_nettype wire

// ----- hdl/chebyshev_stencil_grid_smoother.sv -----
// chebyshev_stencil_grid_smoother: top level, command decode, charge memory, response register
// depends on cssg_pkg, cssg_if, cssg_ram, cssg_csr and cssg_engine
//
// Usage: the req channel carries transactions with cmd, cell_index and charge. A write
// stores one Q8.24 charge and returns nothing; a read returns kind 0 with the cell value;
// a start runs the Chebyshev filter over the whole grid and returns kind 1, value 0.
// The csr channel writes degree_in_use (index 0) and coef_0..coef_6 (indexes 1..7); it is
// always ready and must be written only while the block is idle; the block does not enforce it.
// A read result passes through the registered charge memory read, then the response register.
// A start takes (D+1) grid passes of 32768 cells, where D is the clamped degree: each
// cell reads its 19 stencil taps one per cycle through the single read port of the recurrence
// memory that holds b1, then forms and writes back the new value.
// Results sit in an output register; while the receiver stalls, req stays ready for
// writes and further transactions until a second result would be needed.
// After reset the registers hold degree 1 and zero coefficients; the charge memory holds
// whatever it held and must be written before it is used. No clearing pass is needed.
`default_nettype none
module chebyshev_stencil_grid_smoother (
   input  wire logic clock,
   input  wire logic reset,
   cssg_req_if.sink req_chan,
   cssg_rsp_if.source rsp_chan,
   cssg_csr_if.sink csr_chan
);
   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SMOOTH, ST_DONE} state_type;

   state_type state_ff;
   logic rsp_valid_ff, rsp_kind_ff, oob_ff;
   logic [31:0] rsp_value_ff;

   cssg_pkg::cfg_type cfg;
   cssg_pkg::eng_mem_type eng;
   logic accept, in_grid, slot_free, start, rsp_load;
   logic host_we, host_re;
   logic [cssg_pkg::CHARGE_W-1:0] q_rdata;

   assign accept = req_chan.valid && req_chan.ready;
   assign in_grid = (32'(req_chan.cell_index) < 32'(cssg_pkg::CELLS));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = slot_free && (state_ff == ST_READ || state_ff == ST_DONE);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign start = accept && (req_chan.cmd == cssg_pkg::CMD_START);
   assign host_we = accept && (req_chan.cmd == cssg_pkg::CMD_WRITE) && in_grid;
   assign host_re = accept && (req_chan.cmd == cssg_pkg::CMD_READ) && in_grid;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind = rsp_kind_ff;
   assign rsp_chan.value = rsp_value_ff;

   cssg_csr u_csr (.clock(clock), .reset(reset), .csr_chan(csr_chan), .cfg(cfg));

   cssg_engine u_engine (
      .clock(clock), .reset(reset), .start(start), .cfg(cfg), .q_rdata(q_rdata), .eng(eng)
   );

   cssg_ram #(.WIDTH(cssg_pkg::CHARGE_W), .DEPTH(cssg_pkg::CELLS)) u_charge (
      .clock(clock),
      .we(eng.busy ? eng.we : host_we),
      .waddr(eng.busy ? eng.waddr : cssg_pkg::addr_type'(req_chan.cell_index)),
      .wdata(eng.busy ? eng.wdata : req_chan.charge),
      .re(eng.busy ? eng.re : host_re),
      .raddr(eng.busy ? eng.raddr : cssg_pkg::addr_type'(req_chan.cell_index)),
      .rdata_ff(q_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff <= cssg_pkg::KIND_READ;
         rsp_value_ff <= '0;
         oob_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  oob_ff <= !in_grid;
                  priority case (req_chan.cmd)
                     cssg_pkg::CMD_READ:  state_ff <= ST_READ;
                     cssg_pkg::CMD_START: state_ff <= ST_SMOOTH;
                     default:             state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_READ: begin
               if (slot_free) begin
                  rsp_kind_ff <= cssg_pkg::KIND_READ;
                  rsp_value_ff <= oob_ff ? '0 : q_rdata;
                  state_ff <= ST_IDLE;
               end
            end
            ST_SMOOTH: begin
               if (eng.done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_kind_ff <= cssg_pkg::KIND_DONE;
                  rsp_value_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // host and engine never both drive the charge memory
   assert property (@(posedge clock) disable iff (reset) eng.busy |-> !accept)
      else $error("transaction accepted while engine busy");
   // the engine only finishes while a smoothing transaction is open
   assert property (@(posedge clock) disable iff (reset) eng.done |-> state_ff == ST_SMOOTH)
      else $error("engine done outside smoothing");
   // an accepted start sets the engine busy on the next cycle
   assert property (@(posedge clock) disable iff (reset) start |=> eng.busy)
      else $error("engine did not start");
   // a completion result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == cssg_pkg::KIND_DONE) |-> rsp_value_ff == '0)
      else $error("completion with nonzero value");
endmodule
`default_nettype wire
